// File: rtl/core/ispe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ispe_pkg
// Shared types and constants of the infix sum and product evaluator.
// ----------------------------------------------------------------------------
package ispe_pkg;

  localparam int unsigned MaxNesting = 32;
  localparam int unsigned WordW = 32;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharOpen  = 8'h28;
  localparam logic [7:0] CharClose = 8'h29;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharTimes = 8'h2A;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StToken    = 2'd1,
    StEnd      = 2'd2,
    StOverflow = 2'd3
  } status_e;

  typedef struct packed {
    logic [WordW-1:0] sum;
    logic [WordW-1:0] prod;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_cmd_t;

endpackage

// File: rtl/core/ispe_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ispe_stack
// Parenthesis frame stack: the top frame sits in a register, older frames
// in a synchronous memory, with the frame below the top prefetched.
// ----------------------------------------------------------------------------
module ispe_stack #(
  parameter int unsigned MaxNesting = ispe_pkg::MaxNesting
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ispe_pkg::stack_cmd_t              cmd_i,
  input  ispe_pkg::frame_t                  push_frame_i,
  output ispe_pkg::frame_t                  top_frame_o,
  output logic [$clog2(MaxNesting+1)-1:0]   depth_o
);

  localparam int unsigned DepthW = $clog2(MaxNesting + 1);
  localparam int unsigned AddrW  = (MaxNesting > 1) ? $clog2(MaxNesting) : 1;

  ispe_pkg::frame_t  mem [MaxNesting];
  ispe_pkg::frame_t  top_q;
  ispe_pkg::frame_t  below_q;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [DepthW-1:0] wr_ptr;
  logic [DepthW-1:0] rd_ptr;
  logic              spill;

  always_comb begin
    depth_d = depth_q;
    if (cmd_i.clear) begin
      depth_d = '0;
    end else if (cmd_i.push) begin
      depth_d = depth_q + DepthW'(1);
    end else if (cmd_i.pop) begin
      depth_d = depth_q - DepthW'(1);
    end
  end

  assign spill  = cmd_i.push && (depth_q != '0);
  assign wr_ptr = depth_q - DepthW'(1);
  assign rd_ptr = depth_d - DepthW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // The frame below the top is read at its next address whenever at least two
  // frames will remain; a spill to that same entry is forwarded.
  always_ff @(posedge clk_i) begin
    if (spill) begin
      mem[wr_ptr[AddrW-1:0]] <= top_q;
      below_q <= top_q;
    end else if (depth_d >= DepthW'(2)) begin
      below_q <= mem[rd_ptr[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      top_q <= push_frame_i;
    end else if (cmd_i.pop) begin
      top_q <= below_q;
    end
  end

  assign top_frame_o = top_q;
  assign depth_o     = depth_q;

endmodule

// File: rtl/core/infix_sum_product_evaluator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_sum_product_evaluator_top
// Evaluates a digit, plus, times and parenthesis expression one character
// word at a time and reports the value or the first error at the end word.
//
//   Channel | Handshake                 | Words
//   --------+---------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o   | character_i, end_of_input_i
//   out     | out_valid_o / out_ready_i | status_o, bad_character_o, value_o
//
// One input word is taken every cycle while in_ready_o is high; each step does one add and one
// multiply on the current registers and the stack top register.
// The result of an end word appears on the output in the cycle after it is taken.
// Input stalls only while a result is held and out_ready_i is low.
// Reset clears the evaluator state and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module infix_sum_product_evaluator_top #(
  parameter int unsigned MaxNesting = ispe_pkg::MaxNesting
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         character_i,
  input  logic               end_of_input_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         bad_character_o,
  output logic signed [31:0] value_o
);

  localparam int unsigned DepthW = $clog2(MaxNesting + 1);
  localparam int unsigned WordW  = ispe_pkg::WordW;

  logic                 in_fire;
  logic [WordW-1:0]     sum_q, sum_d;
  logic [WordW-1:0]     prod_q, prod_d;
  logic                 expect_q, expect_d;
  ispe_pkg::status_e    err_q, err_d;
  logic [7:0]           err_char_q, err_char_d;
  logic                 out_valid_q, out_valid_d;
  ispe_pkg::status_e    out_status_q, out_status_d;
  logic [7:0]           out_bad_q, out_bad_d;
  logic [WordW-1:0]     out_value_q, out_value_d;
  ispe_pkg::stack_cmd_t cmd;
  ispe_pkg::frame_t     push_frame;
  ispe_pkg::frame_t     top_frame;
  logic [DepthW-1:0]    depth;
  logic [WordW-1:0]     inner;
  logic [WordW-1:0]     mul_a, mul_b, mul_res;
  logic [7:0]           digit;
  logic                 is_digit;

  ispe_stack #(
    .MaxNesting(MaxNesting)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .push_frame_i(push_frame),
    .top_frame_o (top_frame),
    .depth_o     (depth)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign inner    = sum_q + prod_q;
  assign digit    = character_i - ispe_pkg::CharZero;
  assign is_digit = (character_i >= ispe_pkg::CharZero) && (character_i <= ispe_pkg::CharNine);

  // One multiplier serves both a digit operand and a closing parenthesis.
  assign mul_a   = expect_q ? top_frame.prod : prod_q;
  assign mul_b   = expect_q ? inner : {{(WordW-4){1'b0}}, digit[3:0]};
  assign mul_res = mul_a * mul_b;

  assign push_frame.sum  = sum_q;
  assign push_frame.prod = prod_q;

  always_comb begin
    sum_d        = sum_q;
    prod_d       = prod_q;
    expect_d     = expect_q;
    err_d        = err_q;
    err_char_d   = err_char_q;
    out_status_d = out_status_q;
    out_bad_d    = out_bad_q;
    out_value_d  = out_value_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd          = '0;
    if (in_fire) begin
      if (end_of_input_i) begin
        out_valid_d  = 1'b1;
        out_status_d = err_q;
        out_bad_d    = err_char_q;
        out_value_d  = '0;
        if (err_q == ispe_pkg::StOk) begin
          if (!expect_q || (depth != '0)) begin
            out_status_d = ispe_pkg::StEnd;
            out_bad_d    = '0;
          end else begin
            out_value_d = inner;
          end
        end
        sum_d      = '0;
        prod_d     = WordW'(1);
        expect_d   = 1'b0;
        err_d      = ispe_pkg::StOk;
        err_char_d = '0;
        cmd.clear  = 1'b1;
      end else if (err_q == ispe_pkg::StOk) begin
        if (!expect_q) begin
          if (is_digit) begin
            prod_d   = mul_res;
            expect_d = 1'b1;
          end else if (character_i == ispe_pkg::CharOpen) begin
            if (depth >= DepthW'(MaxNesting)) begin
              err_d = ispe_pkg::StOverflow;
            end else begin
              cmd.push = 1'b1;
              sum_d    = '0;
              prod_d   = WordW'(1);
            end
          end else begin
            err_d      = ispe_pkg::StToken;
            err_char_d = character_i;
          end
        end else begin
          if (character_i == ispe_pkg::CharPlus) begin
            sum_d    = inner;
            prod_d   = WordW'(1);
            expect_d = 1'b0;
          end else if (character_i == ispe_pkg::CharTimes) begin
            expect_d = 1'b0;
          end else if ((character_i == ispe_pkg::CharClose) && (depth != '0)) begin
            cmd.pop = 1'b1;
            sum_d   = top_frame.sum;
            prod_d  = mul_res;
          end else begin
            err_d      = ispe_pkg::StToken;
            err_char_d = character_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      prod_q      <= WordW'(1);
      expect_q    <= 1'b0;
      err_q       <= ispe_pkg::StOk;
      err_char_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      prod_q      <= prod_d;
      expect_q    <= expect_d;
      err_q       <= err_d;
      err_char_q  <= err_char_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_bad_q    <= out_bad_d;
    out_value_q  <= out_value_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign bad_character_o = out_bad_q;
  assign value_o         = out_value_q;

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_input_i |=> out_valid_o)
    else $error("End word did not produce a result.");

  a_end_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_input_i |=> (depth == '0) && !expect_q && (err_q == ispe_pkg::StOk))
    else $error("Evaluator state not cleared after end word.");

  a_error_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ispe_pkg::StOk) |-> (value_o == '0))
    else $error("Nonzero value with an error status.");

  a_bad_char_only_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ispe_pkg::StToken) |-> (bad_character_o == '0))
    else $error("Bad character reported without a token error.");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth <= DepthW'(MaxNesting))
    else $error("Nesting depth beyond its limit.");

endmodule

// File: tb/infix_sum_product_evaluator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_sum_product_evaluator_top_tb
// Self-checking bench for the infix evaluator. Expressions are sent one
// character word at a time and closed by an end word. A behavioral evaluator
// in the bench predicts the status, bad character and value of each end word,
// and a checker compares every result word against those predictions in
// order. Directed tests cover syntax errors, nesting limits, wraparound and
// output back-pressure, then random well-formed, corrupted and noise
// expressions run with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module infix_sum_product_evaluator_top_tb;

  localparam int CycleLimit = 200000;

  typedef struct {
    ispe_pkg::status_e status;
    logic [7:0]        bad;
    logic [31:0]       value;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         character_i;
  logic               end_of_input_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic [7:0]         bad_character_o;
  logic signed [31:0] value_o;

  logic [31:0]       saved_sums [ispe_pkg::MaxNesting];
  logic [31:0]       saved_prods[ispe_pkg::MaxNesting];
  logic [31:0]       run_sum;
  logic [31:0]       run_prod;
  int                open_levels;
  logic              want_operator;
  ispe_pkg::status_e run_status;
  logic [7:0]        run_bad;

  result_t     awaited_results[$];
  logic [7:0]  expr_chars[$];
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          cycle_count = 0;
  int          hold_off_cycles = 0;
  logic        quiet = 1'b0;

  infix_sum_product_evaluator_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .character_i     (character_i),
    .end_of_input_i  (end_of_input_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .bad_character_o (bad_character_o),
    .value_o         (value_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("infix_sum_product_evaluator_top_tb failed");
      $finish;
    end
  end

  task automatic clear_evaluator();
    run_sum = '0;
    run_prod = 32'd1;
    open_levels = 0;
    want_operator = 1'b0;
    run_status = ispe_pkg::StOk;
    run_bad = '0;
  endtask

  task automatic evaluate_word(input logic [7:0] ch, input logic eoi);
    result_t     r;
    logic [31:0] inner;
    if (eoi) begin
      r.status = run_status;
      r.bad = run_bad;
      r.value = '0;
      if (run_status == ispe_pkg::StOk) begin
        if (!want_operator || open_levels != 0) begin
          r.status = ispe_pkg::StEnd;
        end else begin
          r.value = run_sum + run_prod;
        end
      end
      awaited_results.push_back(r);
      clear_evaluator();
    end else if (run_status == ispe_pkg::StOk) begin
      if (!want_operator) begin
        if (ch >= ispe_pkg::CharZero && ch <= ispe_pkg::CharNine) begin
          run_prod = run_prod * {24'd0, ch - ispe_pkg::CharZero};
          want_operator = 1'b1;
        end else if (ch == ispe_pkg::CharOpen) begin
          if (open_levels >= ispe_pkg::MaxNesting) begin
            run_status = ispe_pkg::StOverflow;
          end else begin
            saved_sums[open_levels] = run_sum;
            saved_prods[open_levels] = run_prod;
            open_levels++;
            run_sum = '0;
            run_prod = 32'd1;
          end
        end else begin
          run_status = ispe_pkg::StToken;
          run_bad = ch;
        end
      end else begin
        if (ch == ispe_pkg::CharPlus) begin
          run_sum = run_sum + run_prod;
          run_prod = 32'd1;
          want_operator = 1'b0;
        end else if (ch == ispe_pkg::CharTimes) begin
          want_operator = 1'b0;
        end else if (ch == ispe_pkg::CharClose && open_levels > 0) begin
          inner = run_sum + run_prod;
          open_levels--;
          run_sum = saved_sums[open_levels];
          run_prod = saved_prods[open_levels] * inner;
        end else begin
          run_status = ispe_pkg::StToken;
          run_bad = ch;
        end
      end
    end
  endtask

  task automatic send_word(input logic [7:0] ch, input logic eoi);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    character_i = ch;
    end_of_input_i = eoi;
    do @(posedge clk_i); while (!in_ready_o);
    evaluate_word(ch, eoi);
    words_sent++;
  endtask

  task automatic send_expression();
    foreach (expr_chars[i]) begin
      send_word(expr_chars[i], 1'b0);
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    expr_chars.delete();
    for (int i = 0; i < s.len(); i++) begin
      expr_chars.push_back(s[i]);
    end
    send_expression();
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] grammar_char();
    case ($urandom_range(0, 4))
      0: return 8'(ispe_pkg::CharZero + $urandom_range(0, 9));
      1: return ispe_pkg::CharPlus;
      2: return ispe_pkg::CharTimes;
      3: return ispe_pkg::CharOpen;
      default: return ispe_pkg::CharClose;
    endcase
  endfunction

  task automatic grow_sum(input int levels);
    int terms;
    int factors;
    terms = $urandom_range(1, 3);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) expr_chars.push_back(ispe_pkg::CharPlus);
      factors = $urandom_range(1, 3);
      for (int f = 0; f < factors; f++) begin
        if (f > 0) expr_chars.push_back(ispe_pkg::CharTimes);
        if (levels > 0 && expr_chars.size() < 40 && $urandom_range(0, 3) == 0) begin
          expr_chars.push_back(ispe_pkg::CharOpen);
          grow_sum(levels - 1);
          expr_chars.push_back(ispe_pkg::CharClose);
        end else begin
          expr_chars.push_back(8'(ispe_pkg::CharZero + $urandom_range(0, 9)));
        end
      end
    end
  endtask

  task automatic check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: result word with none expected: status %0d bad %02h value %08h",
                 $realtime, status_o, bad_character_o, value_o);
      end
    end else begin
      want = awaited_results.pop_front();
      if (status_o !== want.status || bad_character_o !== want.bad ||
          value_o !== want.value) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: expected status %0d bad %02h value %08h, got %0d %02h %08h",
                   $realtime, want.status, want.bad, want.value,
                   status_o, bad_character_o, value_o);
        end
      end
    end
  endtask

  initial begin : result_checker
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_ready_i = 1'b0;
        repeat (hold_off_cycles) @(negedge clk_i);
        hold_off_cycles = 0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 6);
        if (stall > 0) begin
          out_ready_i = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result();
    end
  end

  task automatic test_directed();
    send_text("");
    send_text("0+(8*9)");
    send_text("3+");
    send_text("(2");
    send_text(")");
    send_text("1)");
    expr_chars = '{8'h00};
    send_expression();
    expr_chars = '{8'h35, 8'hFF, 8'h31};
    send_expression();
    settle();
  endtask

  task automatic test_nesting_limit();
    expr_chars.delete();
    repeat (ispe_pkg::MaxNesting) expr_chars.push_back(ispe_pkg::CharOpen);
    expr_chars.push_back(8'h37);
    repeat (ispe_pkg::MaxNesting) expr_chars.push_back(ispe_pkg::CharClose);
    send_expression();
    expr_chars.delete();
    repeat (ispe_pkg::MaxNesting + 1) expr_chars.push_back(ispe_pkg::CharOpen);
    expr_chars.push_back(8'h31);
    expr_chars.push_back(ispe_pkg::CharClose);
    send_expression();
    settle();
  endtask

  task automatic test_wraparound();
    expr_chars.delete();
    for (int t = 0; t < 2; t++) begin
      if (t > 0) expr_chars.push_back(ispe_pkg::CharPlus);
      for (int f = 0; f < 10; f++) begin
        if (f > 0) expr_chars.push_back(ispe_pkg::CharTimes);
        expr_chars.push_back(ispe_pkg::CharNine);
      end
    end
    send_expression();
    expr_chars.delete();
    for (int f = 0; f < 12; f++) begin
      if (f > 0) expr_chars.push_back(ispe_pkg::CharTimes);
      expr_chars.push_back(ispe_pkg::CharNine);
    end
    send_expression();
    settle();
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    hold_off_cycles = 80;
    repeat (12) send_text("2*3+1");
    settle();
    quiet = 1'b0;
  endtask

  task automatic test_random_expressions();
    int goal;
    int pick;
    int pos;
    int wraps;
    goal = words_sent + 460;
    while (words_sent < goal) begin
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
      expr_chars.delete();
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        grow_sum(3);
        if ($urandom_range(0, 9) == 0) begin
          wraps = $urandom_range(ispe_pkg::MaxNesting - 3, ispe_pkg::MaxNesting + 1);
          repeat (wraps) expr_chars.push_front(ispe_pkg::CharOpen);
          repeat (wraps) expr_chars.push_back(ispe_pkg::CharClose);
        end
        if (pick >= 6) begin
          pos = $urandom_range(0, expr_chars.size() - 1);
          case ($urandom_range(0, 3))
            0: expr_chars[pos] = 8'($urandom_range(0, 255));
            1: expr_chars[pos] = grammar_char();
            2: while (expr_chars.size() > pos) expr_chars.pop_back();
            default: expr_chars.insert(pos, grammar_char());
          endcase
        end
      end else begin
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 1) == 0) begin
            expr_chars.push_back(8'($urandom_range(0, 255)));
          end else begin
            expr_chars.push_back(grammar_char());
          end
        end
      end
      send_expression();
    end
    quiet = 1'b0;
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    character_i = '0;
    end_of_input_i = 1'b0;
    out_ready_i = 1'b0;
    clear_evaluator();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_nesting_limit();
    test_wraparound();
    test_backpressure();
    test_random_expressions();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("infix_sum_product_evaluator_top_tb passed");
    end else begin
      $display("infix_sum_product_evaluator_top_tb failed");
    end
    $finish;
  end

endmodule
